### rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define BEC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BEC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/bec_pkg.sv
// Types, constants and saturation helpers of the boost energy controller.
package bec_pkg;

   localparam int SIG_W  = 32;
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int WIDE_W = 64;
   localparam int REQ_W  = 160;
   localparam int RSP_W  = 208;
   localparam int CSR_AW = 5;

   localparam logic [15:0] DUTY_MAX = 16'd64225;
   localparam logic [16:0] ONE_Q16  = 17'h10000;

   typedef logic signed [SIG_W-1:0]  sig_type;
   typedef logic signed [MUL_W-1:0]  opnd_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   function automatic wide_type ext64(input sig_type v);
      return {{(WIDE_W-SIG_W){v[SIG_W-1]}}, v};
   endfunction

   function automatic opnd_type sx33(input sig_type v);
      return {v[SIG_W-1], v};
   endfunction

   function automatic opnd_type zx33(input logic [SIG_W-1:0] v);
      return {1'b0, v};
   endfunction

   function automatic sig_type sat32(input wide_type x);
      if (x > 64'sh000000007FFFFFFF) begin
         return 32'sh7FFFFFFF;
      end else if (x < -64'sh0000000080000000) begin
         return 32'sh80000000;
      end
      return x[SIG_W-1:0];
   endfunction

endpackage

### rtl/bec_mul.sv
// Bit-serial signed multiplier, one multiplier bit per cycle.
module bec_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  bec_pkg::opnd_type a,
   input  bec_pkg::opnd_type b,
   output logic              done,
   output bec_pkg::prod_type product
);
   import bec_pkg::*;

   localparam int CNT_W = $clog2(MUL_W + 1);

   logic signed [MUL_W:0] mcand_ff, mcand_in;
   logic signed [MUL_W:0] hi_ff, hi_in;
   logic [MUL_W-1:0]      lo_ff, lo_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  last;
   logic signed [MUL_W:0] addend;
   logic signed [MUL_W:0] hi_sum;

   always_comb begin
      last   = (cnt_ff == CNT_W'(MUL_W - 1));
      // The top multiplier bit carries negative weight, so it subtracts.
      if (lo_ff[0]) begin
         addend = last ? -mcand_ff : mcand_ff;
      end else begin
         addend = '0;
      end
      hi_sum    = hi_ff + addend;
      mcand_in  = mcand_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         mcand_in = {a[MUL_W-1], a};
         hi_in    = '0;
         lo_in    = b;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         hi_in  = {hi_sum[MUL_W], hi_sum[MUL_W:1]};
         lo_in  = {hi_sum[0], lo_ff[MUL_W-1:1]};
         cnt_in = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff[MUL_W-1:0], lo_ff};

endmodule

### rtl/bec_div.sv
// Bit-serial restoring divider, signed dividend over a positive divisor.
module bec_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  bec_pkg::wide_type dividend,
   input  logic [31:0]       divisor,
   output logic              done,
   output bec_pkg::wide_type quotient
);
   import bec_pkg::*;

   localparam int CNT_W = $clog2(WIDE_W + 1);

   logic [WIDE_W-1:0] n_ff, n_in;
   logic [SIG_W-1:0]  rem_ff, rem_in;
   logic [SIG_W-1:0]  dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SIG_W:0]    trial;
   logic [SIG_W+1:0]  diff;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, n_ff[WIDE_W-1]};
      diff    = {1'b0, trial} - {2'b00, dvs_ff};
      ge      = !diff[SIG_W+1];
      n_in    = n_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // Work on magnitudes; the quotient takes the dividend's sign.
         neg_in  = dividend[WIDE_W-1];
         n_in    = dividend[WIDE_W-1] ? -dividend : dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[SIG_W-1:0] : trial[SIG_W-1:0];
         n_in   = {n_ff[WIDE_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(WIDE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -wide_type'(n_ff) : wide_type'(n_ff);

endmodule

### rtl/boost_energy_linearizing_control.sv
// Top level of the boost converter energy feedback linearization controller.
//
//   channel  direction  transfer on                 contents
//   req_     in         req_tvalid & req_tready     five Q12.20 samples, op in tuser
//   rsp_     out        rsp_tvalid & rsp_tready     duty, echo and energy loop values
//   csr_     in/out     psel & penable & pwrite     seven registers at 4*index
//
// All products go through one bit-serial multiplier and all quotients through one
// bit-serial divider; a sequencer walks the steps. An energy step uses the divider
// only for the current reference, and only when the input voltage is positive.
// One transaction is worked on at a time; a new one is taken while the last
// result still waits on rsp_tready. Reset idles the sequencer, drops a pending
// result, sets the registers to their defaults and clears the loop state.
module boost_energy_linearizing_control (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // input_voltage, output_voltage, inductor_current, output_current,
   // voltage_reference, 32 bits each from the lowest bit up
   input  logic [bec_pkg::REQ_W-1:0]   req_tdata,
   // op
   input  logic                        req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // duty_cycle (16), reference_echo, energy_drive, stored_energy, energy_rate,
   // energy_target, filtered_load_current (32 each), from the lowest bit up
   output logic [bec_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [bec_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import bec_pkg::*;

   localparam logic [2:0] REG_IND = 3'd0;
   localparam logic [2:0] REG_CAP = 3'd1;
   localparam logic [2:0] REG_KI  = 3'd2;
   localparam logic [2:0] REG_K1  = 3'd3;
   localparam logic [2:0] REG_K2  = 3'd4;
   localparam logic [2:0] REG_PER = 3'd5;
   localparam logic [2:0] REG_FW  = 3'd6;

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_D_RL   = 5'd1;
   localparam logic [4:0] ST_D_Q    = 5'd2;
   localparam logic [4:0] ST_D_DUTY = 5'd3;
   localparam logic [4:0] ST_E_LI   = 5'd4;
   localparam logic [4:0] ST_E_LI2  = 5'd5;
   localparam logic [4:0] ST_E_CV   = 5'd6;
   localparam logic [4:0] ST_E_CV2  = 5'd7;
   localparam logic [4:0] ST_E_PIN  = 5'd8;
   localparam logic [4:0] ST_E_POUT = 5'd9;
   localparam logic [4:0] ST_E_F1   = 5'd10;
   localparam logic [4:0] ST_E_F2   = 5'd11;
   localparam logic [4:0] ST_E_IP   = 5'd12;
   localparam logic [4:0] ST_E_IDIV = 5'd13;
   localparam logic [4:0] ST_E_LR   = 5'd14;
   localparam logic [4:0] ST_E_LR2  = 5'd15;
   localparam logic [4:0] ST_E_CR   = 5'd16;
   localparam logic [4:0] ST_E_CR2  = 5'd17;
   localparam logic [4:0] ST_E_INT  = 5'd18;
   localparam logic [4:0] ST_E_R1   = 5'd19;
   localparam logic [4:0] ST_E_R2   = 5'd20;
   localparam logic [4:0] ST_E_R3   = 5'd21;
   localparam logic [4:0] ST_OUT    = 5'd22;

   logic [4:0]  step_ff, step_in;
   logic        launch_ff, launch_in;
   logic        op_ff, op_in;
   sig_type     vi_ff, vi_in, vo_ff, vo_in, il_ff, il_in, io_ff, io_in;
   sig_type     echo_ff, echo_in, tmp_ff, tmp_in;
   wide_type    acc_ff, acc_in, dvd_ff, dvd_in;
   logic [31:0] dvs_ff, dvs_in;
   sig_type     e_ff, e_in, edot_ff, edot_in, filt_ff, filt_in;
   sig_type     ilref_ff, ilref_in, eref_ff, eref_in, derr_ff, derr_in;
   logic [15:0] duty_ff, duty_in;
   sig_type     drive_ff, drive_in, href_ff, href_in, iof_ff, iof_in, ierr_ff, ierr_in;
   logic [31:0] ind_ff, cap_ff, ki_ff, k1_ff, k2_ff, per_ff;
   logic [15:0] fw_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   opnd_type    mul_a, mul_b;
   logic        mul_start, mul_done, div_start, div_done;
   prod_type    mul_p;
   wide_type    div_q;
   wide_type    p64, p_sh20, p_sh21, p_sh32, num;
   sig_type     q_v, eref_v, filt_v, rho_v;
   logic        req_fire, csr_we, is_div_step;
   logic [2:0]  csr_idx;
   logic [16:0] fw_rest;

   bec_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   bec_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd_ff),
      .divisor  (dvs_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_tready = (step_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign is_div_step = (step_ff == ST_D_Q) || (step_ff == ST_D_DUTY) ||
                        (step_ff == ST_E_IDIV);
   assign div_start  = launch_ff && is_div_step;
   assign mul_start  = launch_ff && !is_div_step;
   assign fw_rest    = ONE_Q16 - {1'b0, fw_ff};

   assign p64    = mul_p[WIDE_W-1:0];
   assign p_sh20 = WIDE_W'(mul_p >>> 20);
   assign p_sh21 = WIDE_W'(mul_p >>> 21);
   assign p_sh32 = WIDE_W'(mul_p >>> 32);

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (step_ff)
         ST_D_RL:   begin mul_a = sx33(drive_ff); mul_b = zx33(ind_ff);  end
         ST_E_LI:   begin mul_a = sx33(il_ff);    mul_b = zx33(ind_ff);  end
         ST_E_LI2:  begin mul_a = sx33(il_ff);    mul_b = sx33(tmp_ff);  end
         ST_E_CV:   begin mul_a = sx33(vo_ff);    mul_b = zx33(cap_ff);  end
         ST_E_CV2:  begin mul_a = sx33(vo_ff);    mul_b = sx33(tmp_ff);  end
         ST_E_PIN:  begin mul_a = sx33(il_ff);    mul_b = sx33(vi_ff);   end
         ST_E_POUT: begin mul_a = sx33(iof_ff);   mul_b = sx33(vo_ff);   end
         ST_E_F1:   begin mul_a = zx33({16'b0, fw_ff}); mul_b = sx33(io_ff); end
         ST_E_F2:   begin mul_a = zx33({15'b0, fw_rest}); mul_b = sx33(iof_ff); end
         ST_E_IP:   begin mul_a = sx33(filt_ff);  mul_b = sx33(vo_ff);   end
         ST_E_LR:   begin mul_a = sx33(ilref_ff); mul_b = zx33(ind_ff);  end
         ST_E_LR2:  begin mul_a = sx33(ilref_ff); mul_b = sx33(tmp_ff);  end
         ST_E_CR:   begin mul_a = sx33(href_ff);  mul_b = zx33(cap_ff);  end
         ST_E_CR2:  begin mul_a = sx33(href_ff);  mul_b = sx33(tmp_ff);  end
         ST_E_INT:  begin mul_a = sx33(derr_ff);  mul_b = zx33(per_ff);  end
         ST_E_R1:   begin mul_a = sx33(ierr_ff);  mul_b = sx33(ki_ff);   end
         ST_E_R2:   begin mul_a = sx33(e_ff);     mul_b = sx33(k1_ff);   end
         ST_E_R3:   begin mul_a = sx33(edot_ff);  mul_b = sx33(k2_ff);   end
         default:   begin mul_a = '0;             mul_b = '0;            end
      endcase
   end

   // Sequencer: each compute step waits for its unit and folds the result in.
   always_comb begin
      step_in   = step_ff;
      launch_in = 1'b0;
      op_in     = op_ff;
      vi_in     = vi_ff;
      vo_in     = vo_ff;
      il_in     = il_ff;
      io_in     = io_ff;
      echo_in   = echo_ff;
      tmp_in    = tmp_ff;
      acc_in    = acc_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      e_in      = e_ff;
      edot_in   = edot_ff;
      filt_in   = filt_ff;
      ilref_in  = ilref_ff;
      eref_in   = eref_ff;
      derr_in   = derr_ff;
      duty_in   = duty_ff;
      drive_in  = drive_ff;
      href_in   = href_ff;
      iof_in    = iof_ff;
      ierr_in   = ierr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      q_v    = sat32(div_q);
      num    = ext64(q_v) + ext64(vo_ff) - ext64(vi_ff);
      eref_v = sat32(acc_ff + p_sh21);
      filt_v = sat32((acc_ff + p64) >>> 16);
      rho_v  = sat32(acc_ff - p_sh20);

      unique case (step_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in   = req_tuser;
               vi_in   = req_tdata[31:0];
               vo_in   = req_tdata[63:32];
               il_in   = req_tdata[95:64];
               io_in   = req_tdata[127:96];
               echo_in = req_tdata[159:128];
               duty_in = '0;
               if (!req_tuser) begin
                  href_in = req_tdata[159:128];
                  if (!req_tdata[31] && (req_tdata[31:0] != '0) &&
                      !req_tdata[63] && (req_tdata[63:32] != '0)) begin
                     step_in   = ST_D_RL;
                     launch_in = 1'b1;
                  end else begin
                     step_in = ST_OUT;
                  end
               end else begin
                  step_in   = ST_E_LI;
                  launch_in = 1'b1;
               end
            end
         end
         ST_D_RL: begin
            if (mul_done) begin
               dvd_in    = ext64(p_sh32[SIG_W-1:0]) <<< 20;
               dvs_in    = vi_ff;
               step_in   = ST_D_Q;
               launch_in = 1'b1;
            end
         end
         ST_D_Q: begin
            if (div_done) begin
               dvd_in    = num <<< 16;
               dvs_in    = vo_ff;
               step_in   = ST_D_DUTY;
               launch_in = 1'b1;
            end
         end
         ST_D_DUTY: begin
            if (div_done) begin
               if (div_q >= ext64({16'b0, DUTY_MAX})) begin
                  duty_in = DUTY_MAX;
               end else if (div_q <= 64'sd0) begin
                  duty_in = '0;
               end else begin
                  duty_in = div_q[15:0];
               end
               step_in = ST_OUT;
            end
         end
         ST_E_LI, ST_E_CV, ST_E_LR, ST_E_CR: begin
            if (mul_done) begin
               tmp_in    = p_sh32[SIG_W-1:0];
               step_in   = step_ff + 5'd1;
               launch_in = 1'b1;
            end
         end
         ST_E_LI2, ST_E_LR2: begin
            if (mul_done) begin
               acc_in    = p_sh21;
               step_in   = step_ff + 5'd1;
               launch_in = 1'b1;
            end
         end
         ST_E_CV2: begin
            if (mul_done) begin
               e_in      = sat32(acc_ff + p_sh21);
               step_in   = ST_E_PIN;
               launch_in = 1'b1;
            end
         end
         ST_E_PIN: begin
            if (mul_done) begin
               acc_in    = p_sh20;
               step_in   = ST_E_POUT;
               launch_in = 1'b1;
            end
         end
         ST_E_POUT: begin
            if (mul_done) begin
               edot_in   = sat32(acc_ff - p_sh20);
               step_in   = ST_E_F1;
               launch_in = 1'b1;
            end
         end
         ST_E_F1: begin
            if (mul_done) begin
               acc_in    = p64;
               step_in   = ST_E_F2;
               launch_in = 1'b1;
            end
         end
         ST_E_F2: begin
            if (mul_done) begin
               filt_in   = filt_v;
               iof_in    = filt_v;
               launch_in = 1'b1;
               // Without a positive input voltage the current reference is zero.
               if (!vi_ff[31] && (vi_ff != '0)) begin
                  step_in = ST_E_IP;
               end else begin
                  ilref_in = '0;
                  step_in  = ST_E_LR;
               end
            end
         end
         ST_E_IP: begin
            if (mul_done) begin
               dvd_in    = p64;
               dvs_in    = vi_ff;
               step_in   = ST_E_IDIV;
               launch_in = 1'b1;
            end
         end
         ST_E_IDIV: begin
            if (div_done) begin
               ilref_in  = q_v;
               step_in   = ST_E_LR;
               launch_in = 1'b1;
            end
         end
         ST_E_CR2: begin
            if (mul_done) begin
               eref_in   = eref_v;
               derr_in   = sat32(ext64(eref_v) - ext64(e_ff));
               step_in   = ST_E_INT;
               launch_in = 1'b1;
            end
         end
         ST_E_INT: begin
            if (mul_done) begin
               ierr_in   = sat32(ext64(ierr_ff) + p_sh32);
               step_in   = ST_E_R1;
               launch_in = 1'b1;
            end
         end
         ST_E_R1: begin
            if (mul_done) begin
               acc_in    = p_sh20;
               step_in   = ST_E_R2;
               launch_in = 1'b1;
            end
         end
         ST_E_R2: begin
            if (mul_done) begin
               acc_in    = acc_ff - p_sh20;
               step_in   = ST_E_R3;
               launch_in = 1'b1;
            end
         end
         ST_E_R3: begin
            if (mul_done) begin
               drive_in = rho_v;
               step_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (op_ff) begin
                  rsp_data_in = {filt_ff, eref_ff, edot_ff, e_ff, drive_ff, 32'b0, 16'b0};
               end else begin
                  rsp_data_in = {160'b0, echo_ff, duty_ff};
               end
               step_in = ST_IDLE;
            end
         end
         default: begin
            step_in = ST_IDLE;
         end
      endcase
   end

   assign csr_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_idx)
         REG_IND: csr_prdata = ind_ff;
         REG_CAP: csr_prdata = cap_ff;
         REG_KI:  csr_prdata = ki_ff;
         REG_K1:  csr_prdata = k1_ff;
         REG_K2:  csr_prdata = k2_ff;
         REG_PER: csr_prdata = per_ff;
         REG_FW:  csr_prdata = {16'b0, fw_ff};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ind_ff <= '0;
         cap_ff <= '0;
         ki_ff  <= '0;
         k1_ff  <= '0;
         k2_ff  <= '0;
         per_ff <= '0;
         fw_ff  <= 16'd655;
      end else if (csr_we) begin
         unique case (csr_idx)
            REG_IND: ind_ff <= csr_pwdata;
            REG_CAP: cap_ff <= csr_pwdata;
            REG_KI:  ki_ff  <= csr_pwdata;
            REG_K1:  k1_ff  <= csr_pwdata;
            REG_K2:  k2_ff  <= csr_pwdata;
            REG_PER: per_ff <= csr_pwdata;
            REG_FW:  fw_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      vi_ff       <= vi_in;
      vo_ff       <= vo_in;
      il_ff       <= il_in;
      io_ff       <= io_in;
      echo_ff     <= echo_in;
      tmp_ff      <= tmp_in;
      acc_ff      <= acc_in;
      dvd_ff      <= dvd_in;
      dvs_ff      <= dvs_in;
      e_ff        <= e_in;
      edot_ff     <= edot_in;
      filt_ff     <= filt_in;
      ilref_ff    <= ilref_in;
      eref_ff     <= eref_in;
      derr_ff     <= derr_in;
      duty_ff     <= duty_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         step_ff      <= ST_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         drive_ff     <= '0;
         href_ff      <= '0;
         iof_ff       <= '0;
         ierr_ff      <= '0;
      end else begin
         step_ff      <= step_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
         drive_ff     <= drive_in;
         href_ff      <= href_in;
         iof_ff       <= iof_in;
         ierr_ff      <= ierr_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/bec_checker.sv
// Port-level checks of the boost energy controller, bound to the top level.
`include "assert_macros.svh"

module bec_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [bec_pkg::REQ_W-1:0]   req_tdata,
   input logic                        req_tuser,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [bec_pkg::RSP_W-1:0]   rsp_tdata,
   input logic                        csr_psel,
   input logic                        csr_penable,
   input logic                        csr_pwrite,
   input logic [bec_pkg::CSR_AW-1:0]  csr_paddr,
   input logic [31:0]                 csr_pwdata,
   input logic [31:0]                 csr_prdata,
   input logic                        csr_pready
);
   import bec_pkg::*;

   // A stalled result keeps its data.
   `BEC_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   // Only one transaction is in work at a time.
   `BEC_ASSERT(a_one_in_work, req_tvalid && req_tready |=> !req_tready, "second transaction taken while busy")
   // The duty never exceeds its clamp.
   `BEC_ASSERT(a_duty_clamp, rsp_tvalid |-> rsp_tdata[15:0] <= DUTY_MAX, "duty above clamp")
   // Reset leaves no result pending.
   `BEC_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind boost_energy_linearizing_control bec_checker u_bec_checker (.*);

### tb/boost_energy_linearizing_control_tb.sv
// Self-checking testbench for the boost converter energy feedback linearization controller.
module boost_energy_linearizing_control_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bec_pkg::*;

   localparam int CSR_INDUCTANCE   = 0;
   localparam int CSR_CAPACITANCE  = 1;
   localparam int CSR_GAIN_INT     = 2;
   localparam int CSR_GAIN_ENERGY  = 3;
   localparam int CSR_GAIN_RATE    = 4;
   localparam int CSR_PERIOD       = 5;
   localparam int CSR_FILTER_W     = 6;
   localparam int CSR_UNUSED       = 7;
   localparam bit OP_DUTY          = 1'b0;
   localparam bit OP_ENERGY        = 1'b1;
   localparam int WATCHDOG_CYCLES  = 5000;
   localparam int SETTLE_CYCLES    = 800;
   localparam int RANDOM_PER_PHASE = 230;

   // Predicts the controller outputs and holds them until the matching transaction arrives.
   class energy_loop_scoreboard;
      bit [31:0] l_val, c_val, ki, k1, k2, period, weight;
      longint    rho, vref_held, iof, err_acc;
      bit [RSP_W-1:0] pending[$];
      int mismatches;
      int checked;
      int duty_steps, energy_steps;

      function new();
         l_val = 0; c_val = 0; ki = 0; k1 = 0; k2 = 0; period = 0; weight = 655;
         rho = 0; vref_held = 0; iof = 0; err_acc = 0;
         mismatches = 0; checked = 0; duty_steps = 0; energy_steps = 0;
      endfunction

      function void set_register(int idx, bit [31:0] value);
         case (idx)
            CSR_INDUCTANCE:  l_val = value;
            CSR_CAPACITANCE: c_val = value;
            CSR_GAIN_INT:    ki = value;
            CSR_GAIN_ENERGY: k1 = value;
            CSR_GAIN_RATE:   k2 = value;
            CSR_PERIOD:      period = value;
            CSR_FILTER_W:    weight = {16'd0, value[15:0]};
            default: ;
         endcase
      endfunction

      function longint clip(longint x);
         if (x > 64'sd2147483647) return 64'sd2147483647;
         if (x < -64'sd2147483648) return -64'sd2147483648;
         return x;
      endfunction

      function longint uext(bit [31:0] v);
         return longint'({32'd0, v});
      endfunction

      function longint sext(bit [31:0] v);
         return longint'(signed'(v));
      endfunction

      // X*q^2/2 with X unsigned Q0.32 and q in Q12.20, floored at each shift.
      function longint half_sq_energy(longint q, bit [31:0] x);
         longint qx;
         qx = (q * uext(x)) >>> 32;
         return (q * qx) >>> 21;
      endfunction

      function longint qmul(longint a, longint b);
         return (a * b) >>> 20;
      endfunction

      function void note_sample(bit op, bit [REQ_W-1:0] d);
         bit [RSP_W-1:0] res;
         longint vi, vo, il, io, vr;
         longint duty, rl, q, num, e, edot, filt, ilref, eref, derr;
         vi = sext(d[31:0]);
         vo = sext(d[63:32]);
         il = sext(d[95:64]);
         io = sext(d[127:96]);
         vr = sext(d[159:128]);
         res = '0;
         if (op == OP_DUTY) begin
            duty_steps++;
            duty = 0;
            vref_held = vr;
            if (vi > 0 && vo > 0) begin
               rl = (rho * uext(l_val)) >>> 32;
               q = clip((rl * 1048576) / vi);
               num = q + vo - vi;
               duty = (num * 65536) / vo;
               if (duty >= longint'(DUTY_MAX)) duty = longint'(DUTY_MAX);
               if (duty <= 0) duty = 0;
            end
            res[15:0] = duty[15:0];
            res[47:16] = vr[31:0];
         end else begin
            energy_steps++;
            e = clip(half_sq_energy(il, l_val) + half_sq_energy(vo, c_val));
            // The rate term uses the filter state from before this update.
            edot = clip(qmul(il, vi) - qmul(iof, vo));
            filt = clip((uext(weight) * io + (65536 - uext(weight)) * iof) >>> 16);
            iof = filt;
            ilref = 0;
            if (vi > 0) ilref = clip((filt * vo) / vi);
            eref = clip(half_sq_energy(ilref, l_val) + half_sq_energy(vref_held, c_val));
            derr = clip(eref - e);
            err_acc = clip(err_acc + ((derr * uext(period)) >>> 32));
            rho = clip(qmul(err_acc, sext(ki)) - qmul(e, sext(k1)) - qmul(edot, sext(k2)));
            res[79:48]   = rho[31:0];
            res[111:80]  = e[31:0];
            res[143:112] = edot[31:0];
            res[175:144] = eref[31:0];
            res[207:176] = filt[31:0];
         end
         pending.push_back(res);
      endfunction

      function void check_result(bit [RSP_W-1:0] got);
         bit [RSP_W-1:0] want;
         string names[7];
         int lo, wd;
         names = '{"duty_cycle", "reference_echo", "energy_drive", "stored_energy",
                   "energy_rate", "energy_target", "filtered_load_current"};
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
            return;
         end
         want = pending.pop_front();
         checked++;
         for (int f = 0; f < 7; f++) begin
            lo = (f == 0) ? 0 : 16 + 32 * (f - 1);
            wd = (f == 0) ? 16 : 32;
            if (((got >> lo) & ((208'd1 << wd) - 1)) != ((want >> lo) & ((208'd1 << wd) - 1)))
            begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: result %0d field %s expected %h actual %h", checked,
                           names[f], (want >> lo) & ((208'd1 << wd) - 1),
                           (got >> lo) & ((208'd1 << wd) - 1));
            end
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;
   logic              req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   energy_loop_scoreboard board;
   bit  quiet_tail;
   bit  req_seen, rsp_seen;
   int  idle_cycles;

   boost_energy_linearizing_control uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Inputs only change at rising edges, so the negative edge sees what the next
   // rising edge will act on.
   always @(negedge clock) begin
      req_seen <= req_tvalid && req_tready;
      rsp_seen <= rsp_tvalid && rsp_tready;
   end

   // Result side: check each transaction and stall at random in bursts outside the quiet tail.
   initial begin
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_seen) board.check_result(rsp_tdata);
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 7) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      idle_cycles = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (req_seen || rsp_seen) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("ERROR: no transaction for %0d cycles", WATCHDOG_CYCLES);
            $display("** boost_energy_linearizing_control: FAILED **");
            $finish;
         end
      end
   end

   task automatic csr_write(int idx, bit [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(4 * idx);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.set_register(idx, value);
   endtask

   task automatic wait_drained();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sends one transaction; valid stays high into the next one unless a gap follows.
   task automatic send_sample(bit op, bit [REQ_W-1:0] d);
      int gap;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= op;
      do @(posedge clock); while (!req_seen);
      board.note_sample(op, d);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic bit [31:0] volts(int lo_mv, int hi_mv);
      longint v;
      v = (longint'($urandom_range(0, hi_mv - lo_mv)) + lo_mv) * 1048576 / 1000;
      return v[31:0];
   endfunction

   function automatic bit [31:0] any_value();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'd0;
         default: return $urandom;
      endcase
   endfunction

   // Mostly plausible converter operating points, with some wild values mixed in.
   function automatic bit [REQ_W-1:0] make_sample();
      bit [REQ_W-1:0] d;
      if ($urandom_range(0, 3) == 0) begin
         d = {any_value(), any_value(), any_value(), any_value(), any_value()};
      end else begin
         d[31:0]    = volts(-500, 16000);
         d[63:32]   = volts(-500, 40000);
         d[95:64]   = volts(-1000, 8000);
         d[127:96]  = volts(-500, 4000);
         d[159:128] = volts(18000, 36000);
      end
      return d;
   endfunction

   task automatic load_config(bit [31:0] l, bit [31:0] c, bit [31:0] gi, bit [31:0] ge,
                              bit [31:0] gr, bit [31:0] per, bit [31:0] w);
      csr_write(CSR_INDUCTANCE, l);
      csr_write(CSR_CAPACITANCE, c);
      csr_write(CSR_GAIN_INT, gi);
      csr_write(CSR_GAIN_ENERGY, ge);
      csr_write(CSR_GAIN_RATE, gr);
      csr_write(CSR_PERIOD, per);
      csr_write(CSR_FILTER_W, w);
   endtask

   task automatic random_phase(int count);
      for (int n = 0; n < count; n++)
         send_sample(($urandom_range(0, 2) == 0) ? OP_DUTY : OP_ENERGY, make_sample());
      end_burst();
      wait_drained();
   endtask

   function automatic bit [31:0] moderate_gain();
      int g;
      g = $urandom_range(0, 8 << 20);
      return ($urandom_range(0, 1) != 0) ? 32'(g) : 32'(-g);
   endfunction

   initial begin
      bit [31:0] v;
      board = new();
      quiet_tail = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under reset defaults: sign corners of the voltages.
      send_sample(OP_DUTY,   {32'd25 << 20, 32'd0, 32'd0, 32'd24 << 20, 32'd12 << 20});
      send_sample(OP_DUTY,   {32'd25 << 20, 32'd0, 32'd0, 32'd24 << 20, 32'd0});
      send_sample(OP_DUTY,   {32'd25 << 20, 32'd0, 32'd0, 32'hFFF00000, 32'd12 << 20});
      send_sample(OP_ENERGY, {32'd25 << 20, 32'd1 << 20, 32'd2 << 20, 32'd24 << 20, 32'd0});
      end_burst();
      wait_drained();

      // Plant-like values with strong gains to drive the duty into both clamps.
      load_config(32'd429497, 32'd2018634, 32'h00100000, 32'hFFF00000, 32'h00080000,
                  32'd429497, 32'd655);
      csr_write(CSR_UNUSED, 32'hFFFFFFFF);
      send_sample(OP_DUTY,   {32'd24 << 20, 32'd2 << 20, 32'd3 << 20, 32'd24 << 20,
                              32'd12 << 20});
      send_sample(OP_ENERGY, {32'd24 << 20, 32'd1 << 20, 32'd3 << 20, 32'd24 << 20,
                              32'd12 << 20});
      send_sample(OP_ENERGY, {32'd30 << 20, 32'd0, 32'd5 << 20, 32'd20 << 20, 32'd0});
      send_sample(OP_ENERGY, {32'd30 << 20, 32'd2 << 20, 32'd5 << 20, 32'd20 << 20,
                              32'hFFF00000});
      send_sample(OP_DUTY,   {32'd24 << 20, 32'd0, 32'd0, 32'd24 << 20, 32'd1});
      send_sample(OP_DUTY,   {32'd24 << 20, 32'd0, 32'd0, 32'd1, 32'd20 << 20});
      send_sample(OP_DUTY,   {32'd24 << 20, 32'd0, 32'd0, 32'd30 << 20, 32'd1 << 10});
      send_sample(OP_DUTY,   {32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                              32'h7FFFFFFF});
      send_sample(OP_DUTY,   {32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                              32'h80000000});
      send_sample(OP_ENERGY, {32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                              32'h7FFFFFFF});
      send_sample(OP_ENERGY, {32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                              32'h80000000});
      send_sample(OP_ENERGY, {32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                              32'd1});
      send_sample(OP_DUTY,   {32'd0, 32'd0, 32'd0, 32'h7FFFFFFF, 32'd1});
      end_burst();
      wait_drained();

      // Extremes of every register, then random phases.
      load_config(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                  32'hFFFFFFFF, 32'h0000FFFF);
      random_phase(RANDOM_PER_PHASE / 2);
      load_config(32'd0, 32'd0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'd0,
                  32'hFFFF0000);
      random_phase(RANDOM_PER_PHASE / 2);
      load_config(32'd429497, 32'd2018634, moderate_gain(), moderate_gain(),
                  moderate_gain(), 32'd429497, 32'd655);
      random_phase(RANDOM_PER_PHASE);
      load_config($urandom_range(0, 1 << 24), $urandom_range(0, 1 << 24), moderate_gain(),
                  moderate_gain(), moderate_gain(), $urandom_range(0, 1 << 26),
                  $urandom_range(0, 65535));
      random_phase(RANDOM_PER_PHASE);
      v = $urandom;
      load_config(v, ~v, $urandom, $urandom, $urandom, ~$urandom, $urandom);
      random_phase(RANDOM_PER_PHASE);
      load_config(32'd858993, 32'd4037269, moderate_gain(), moderate_gain(),
                  moderate_gain(), 32'd214748, 32'd6554);
      quiet_tail = 1'b1;
      random_phase(RANDOM_PER_PHASE);

      $display("Covered %0d duty steps and %0d energy steps over eight register settings,",
               board.duty_steps, board.energy_steps);
      $display("with %0d results checked and %0d mismatches.", board.checked,
               board.mismatches);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("** boost_energy_linearizing_control: PASSED **");
      end else begin
         if (board.pending.size() != 0)
            $display("ERROR: %0d results never arrived", board.pending.size());
         $display("** boost_energy_linearizing_control: FAILED **");
      end
      $finish;
   end

endmodule
